[src/distinct_count_min_max_assert.svh]
// Assertion macros shared by the distinct count block.
`ifndef DISTINCT_COUNT_MIN_MAX_ASSERT_SVH
`define DISTINCT_COUNT_MIN_MAX_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DCMM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DCMM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/dcmm_pkg.sv]
// Types and constants for the distinct count, min and max block.
`default_nettype none
package dcmm_pkg;

	localparam int unsigned DCMM_DEPTH = 1024;
	localparam int unsigned DCMM_CNT_W = 11;

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} in_t;

	typedef struct packed {
		logic [DCMM_CNT_W-1:0] distinct_count;
		logic signed [31:0]    largest;
		logic signed [31:0]    smallest;
		logic                  overflow;
	} out_t;

	typedef struct packed {
		logic               valid;
		logic signed [31:0] value;
		logic               last;
		logic               hit;
		logic               stored;
	} beat_t;

endpackage
`default_nettype wire

[src/distinct_count_min_max.sv]
// Distinct count, min and max over runs: row of store cells plus result stage.
// A run's last beat passes through every cell register in turn, then into the result register.
// Throughput: one beat per cycle while the row is not stalled; beats ride the cell row one cell a cycle.
// The row stalls only when a result is due while the previous one is unread.
// Reset clears cell occupancy, run state and the result valid flag at once.
`default_nettype none
module distinct_count_min_max #(
	parameter int unsigned DEPTH = dcmm_pkg::DCMM_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  dcmm_pkg::in_t  item,
	output logic           result_valid,
	input  logic           result_ready,
	output dcmm_pkg::out_t result
);
	import dcmm_pkg::*;

	beat_t chain [DEPTH+1];
	logic  adv;

	always_comb begin
		chain[0].valid  = item_valid;
		chain[0].value  = item.value;
		chain[0].last   = item.last;
		chain[0].hit    = 1'b0;
		chain[0].stored = 1'b0;
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		dcmm_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.up     (chain[i]),
			.dn     (chain[i+1])
		);
	end

	dcmm_tail #(
		.DEPTH (DEPTH)
	) u_tail (
		.clk          (clk),
		.arst_n       (arst_n),
		.beat         (chain[DEPTH]),
		.result_ready (result_ready),
		.adv          (adv),
		.result_valid (result_valid),
		.result       (result)
	);

	assign item_ready = adv;

endmodule
`default_nettype wire

[src/dcmm_cell.sv]
// One store cell: holds a distinct value and passes each beat to its neighbor.
`default_nettype none
module dcmm_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  dcmm_pkg::beat_t up,
	output dcmm_pkg::beat_t dn
);
	import dcmm_pkg::*;

	logic               full_q;
	logic signed [31:0] held_q;
	beat_t              dn_q;
	beat_t              nx;
	logic               match;
	logic               take_new;

	always_comb begin
		match      = full_q && (held_q == up.value);
		take_new   = up.valid && !up.hit && !full_q;
		nx         = up;
		nx.hit     = up.hit | match | take_new;
		nx.stored  = up.stored | take_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			dn_q   <= '0;
		end else if (adv) begin
			dn_q <= nx;
			if (up.valid && up.last) begin
				full_q <= 1'b0;
			end else if (take_new) begin
				full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take_new) begin
			held_q <= up.value;
		end
	end

	assign dn = dn_q;

endmodule
`default_nettype wire

[src/dcmm_tail.sv]
// End of the cell row: count, min, max, overflow and the result register.
`default_nettype none
module dcmm_tail #(
	parameter int unsigned DEPTH = dcmm_pkg::DCMM_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  dcmm_pkg::beat_t beat,
	input  logic            result_ready,
	output logic            adv,
	output logic            result_valid,
	output dcmm_pkg::out_t  result
);
	import dcmm_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [CW-1:0]      cnt_q;
	logic signed [31:0] max_q;
	logic signed [31:0] min_q;
	logic               ovf_q;
	logic               started_q;
	logic               res_valid_q;
	logic [CW-1:0]      res_cnt_q;
	logic signed [31:0] res_max_q;
	logic signed [31:0] res_min_q;
	logic               res_ovf_q;

	logic [CW-1:0]          cnt_nx;
	logic signed [31:0]     max_nx;
	logic signed [31:0]     min_nx;
	logic                   ovf_nx;
	logic                   take;
	logic [CW+DCMM_CNT_W-1:0] cnt_ext;

	always_comb begin
		cnt_nx = cnt_q + CW'(beat.stored);
		max_nx = (!started_q || (beat.value > max_q)) ? beat.value : max_q;
		min_nx = (!started_q || (beat.value < min_q)) ? beat.value : min_q;
		ovf_nx = ovf_q | !beat.hit;
		adv    = !(res_valid_q && !result_ready && beat.valid && beat.last);
		take   = adv && beat.valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			max_q       <= '0;
			min_q       <= '0;
			ovf_q       <= 1'b0;
			started_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				if (beat.last) begin
					cnt_q     <= '0;
					max_q     <= '0;
					min_q     <= '0;
					ovf_q     <= 1'b0;
					started_q <= 1'b0;
				end else begin
					cnt_q     <= cnt_nx;
					max_q     <= max_nx;
					min_q     <= min_nx;
					ovf_q     <= ovf_nx;
					started_q <= 1'b1;
				end
			end
			if (take && beat.last) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && beat.last) begin
			res_cnt_q <= cnt_nx;
			res_max_q <= max_nx;
			res_min_q <= min_nx;
			res_ovf_q <= ovf_nx;
		end
	end

	always_comb begin
		cnt_ext               = {{DCMM_CNT_W{1'b0}}, res_cnt_q};
		result.distinct_count = cnt_ext[DCMM_CNT_W-1:0];
		result.largest        = res_max_q;
		result.smallest       = res_min_q;
		result.overflow       = res_ovf_q;
	end

	assign result_valid = res_valid_q;

`include "distinct_count_min_max_assert.svh"

	`DCMM_ASSERT_IMP(a_ovf_full, res_valid_q && res_ovf_q, res_cnt_q == CW'(DEPTH), "overflow with store not full")
	`DCMM_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= CW'(DEPTH), "distinct count beyond store depth")
	`DCMM_ASSERT_NXT(a_stall_hold, !adv, $stable(cnt_q) && $stable(started_q), "run state moved during stall")

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for distinct_count_min_max: directed and random runs checked against a run tracker.
module tb_top;
	import dcmm_pkg::*;

	localparam int unsigned DEPTH        = DCMM_DEPTH;
	localparam int unsigned DRAIN_CYCLES = DEPTH + 40;
	localparam int unsigned STALL_LIMIT  = 20000;
	localparam int unsigned HOLD_CYCLES  = 3000;
	localparam int unsigned RANDOM_BEATS = 60;
	localparam int unsigned PRESSURE_BEATS = 250;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_t  item;
	logic result_valid;
	logic result_ready;
	out_t result;

	logic [31:0]        seen_vals[$];
	logic signed [31:0] run_min = '0;
	logic signed [31:0] run_max = '0;
	logic               run_overflow = 1'b0;
	logic               run_open = 1'b0;
	out_t               pending_results[$];

	logic signed [31:0] run_vals[$];
	int mismatches = 0;
	int beats_sent = 0;
	int idle_cycles = 0;
	int hold_request = 0;
	bit sender_idles = 1'b1;
	bit receiver_idles = 1'b1;

	distinct_count_min_max DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	always #1 clk = ~clk;

	function automatic void track_beat(in_t b);
		bit   hit;
		out_t r;
		hit = 1'b0;
		if (!run_open) begin
			run_min = b.value;
			run_max = b.value;
			run_open = 1'b1;
		end else begin
			if ($signed(b.value) < run_min) run_min = b.value;
			if ($signed(b.value) > run_max) run_max = b.value;
		end
		foreach (seen_vals[i]) begin
			if (seen_vals[i] == b.value) hit = 1'b1;
		end
		if (!hit) begin
			if (seen_vals.size() < DEPTH) seen_vals.push_back(b.value);
			else run_overflow = 1'b1;
		end
		if (b.last) begin
			r.distinct_count = DCMM_CNT_W'(seen_vals.size());
			r.largest = run_max;
			r.smallest = run_min;
			r.overflow = run_overflow;
			pending_results.push_back(r);
			seen_vals.delete();
			run_min = '0;
			run_max = '0;
			run_overflow = 1'b0;
			run_open = 1'b0;
		end
	endfunction

	function automatic void note_mismatch(string what, out_t want, out_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected count=%0d max=%0d min=%0d ovf=%0b,",
				$time, what, want.distinct_count, $signed(want.largest),
				$signed(want.smallest), want.overflow);
			$display("    got count=%0d max=%0d min=%0d ovf=%0b",
				got.distinct_count, $signed(got.largest), $signed(got.smallest),
				got.overflow);
		end
	endfunction

	function automatic void check_result(out_t got);
		out_t want;
		if (pending_results.size() == 0) begin
			note_mismatch("result with no run pending", '0, got);
			return;
		end
		want = pending_results.pop_front();
		if (got.distinct_count !== want.distinct_count || got.largest !== want.largest ||
			got.smallest !== want.smallest || got.overflow !== want.overflow) begin
			note_mismatch("run result mismatch", want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && item_valid && item_ready) track_beat(item);
		if (arst_n && result_valid && result_ready) check_result(result);
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int stall;
		result_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = receiver_idles ? $urandom_range(0, 9) : 0;
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
			end
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			while (!result_valid && hold_request == 0) @(posedge clk);
			receiver_idles = ($urandom_range(0, 3) != 0);
		end
	end

	task automatic send_beat(input logic signed [31:0] v, input logic l);
		int  gap;
		in_t b;
		gap = sender_idles ? $urandom_range(0, 9) : 0;
		b.value = v;
		b.last = l;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= b;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		beats_sent++;
	endtask

	task automatic send_run();
		int i;
		for (i = 0; i < run_vals.size(); i++) begin
			send_beat(run_vals[i], i == run_vals.size() - 1);
		end
	endtask

	function automatic logic signed [31:0] draw_value();
		case ($urandom_range(0, 5))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(0, 5))
					0: return 32'sh8000_0000;
					1: return 32'sh8000_0001;
					2: return 32'sh7fff_ffff;
					3: return 32'sh7fff_fffe;
					4: return 32'sd0;
					default: return -32'sd1;
				endcase
			end
			default: return $signed(32'($urandom_range(0, 15))) - 32'sd8;
		endcase
	endfunction

	task automatic test_single_item_runs();
		run_vals = '{32'sh8000_0000}; send_run();
		run_vals = '{32'sh7fff_ffff}; send_run();
		run_vals = '{32'sd0}; send_run();
		run_vals = '{-32'sd1}; send_run();
		run_vals = '{32'sd1}; send_run();
	endtask

	task automatic test_min_max_and_repeats();
		run_vals = '{-32'sd10, -32'sd20}; send_run();
		run_vals = '{32'sd10, 32'sd20, 32'sd20, 32'sd10}; send_run();
		run_vals = '{32'sd7, 32'sd7, 32'sd7}; send_run();
		run_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, -32'sd1}; send_run();
		run_vals = '{32'sd3, -32'sd3, 32'sd3}; send_run();
	endtask

	task automatic test_store_full();
		int unsigned i;
		// fill the store, repeat a stored value, then add new extremes past it
		run_vals.delete();
		for (i = 0; i < DEPTH; i++) run_vals.push_back(32'(1000 + 3 * i));
		run_vals.push_back(32'sd1000);
		run_vals.push_back(32'sh7fff_ffff);
		run_vals.push_back(32'sh8000_0000);
		send_run();
	endtask

	task automatic test_result_backpressure();
		int start_count;
		int len;
		int i;
		start_count = beats_sent;
		sender_idles = 1'b1;
		hold_request = HOLD_CYCLES;
		while (beats_sent - start_count < PRESSURE_BEATS) begin
			len = $urandom_range(1, 8);
			run_vals.delete();
			for (i = 0; i < len; i++) run_vals.push_back(draw_value());
			send_run();
		end
		sender_idles = 1'b1;
	endtask

	task automatic test_random_runs();
		int start_count;
		int len;
		int i;
		start_count = beats_sent;
		while (beats_sent - start_count < RANDOM_BEATS) begin
			sender_idles = ($urandom_range(0, 3) != 0);
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
			run_vals.delete();
			for (i = 0; i < len; i++) run_vals.push_back(draw_value());
			send_run();
		end
		sender_idles = 1'b1;
	endtask

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_item_runs();
		test_min_max_and_repeats();
		test_store_full();
		test_result_backpressure();
		test_random_runs();
		item_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
